// File: hw/rtl/rpn_pkg.sv
// rpn_pkg: shared types and constants for the reverse Polish evaluator
// token kinds, operator codes, status codes and the control state type
// no dependencies
`timescale 1ns / 1ps

package rpn_pkg;

    // data and stack sizing
    localparam int DATA_W            = 32;
    localparam int STACK_DEPTH_DEF   = 16;

    // token kinds
    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_OP    = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes, also used as the sticky error
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // signed 32-bit limits
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

    // control states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

endpackage

// File: hw/rtl/rpn_ram.sv
// rpn_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rpn_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/rpn_div.sv
// rpn_div: iterative signed 32-bit divider, one quotient bit per cycle
// quotient truncated toward zero; depends on rpn_pkg
`timescale 1ns / 1ps

module rpn_div
    import rpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int CW = $clog2(DATA_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg, n_neg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // one restoring step on the magnitudes
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_dvs  = i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                n_rem = diff[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    // sign fix on the way out
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// File: hw/rtl/rpn_stack_evaluator_top.sv
// rpn_stack_evaluator_top: reverse Polish integer expression evaluator
// depends on rpn_pkg, rpn_ram and rpn_div
//
// Usage
//   Input channel (i_valid / o_stall) carries one token per transaction:
//   i_kind selects digit, operator or end; i_digit_value and i_op_code
//   give the operand or the operator. Kind 3 is taken and ignored.
//   Output channel (o_valid / i_stall) carries one transaction per end
//   token: o_value and o_status (0 ok, 1 malformed, 2 overflow,
//   3 division by zero, 4 stack full); o_value is zero unless ok.
//   Per token: digit, end and ignored tokens, and operators that lack
//   operands or meet a pending error, finish in S_IDLE; add and subtract
//   pass through S_READ; multiply through S_READ and S_MUL; divide through
//   S_READ (operand read, divider start), S_DIV and S_WAIT (write back),
//   waiting on the one-bit-per-cycle divider (32 steps); a zero divisor or an overflowing quotient ends in S_READ.
//   Operators read the first operand from the stack ram (registered
//   read); the top of stack, the second operand, lives in a register.
//   The result of an end token appears on o_valid the cycle after it is
//   taken and stays, unchanged, while i_stall is high. Digit and operator
//   tokens are still taken meanwhile; only a further end token waits.
//   Reset (i_rst_n low, synchronous) empties the stack, clears the error
//   and drops o_valid; ram contents are not cleared and need no sweep.
`timescale 1ns / 1ps

module rpn_stack_evaluator_top
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_kind,
    input  logic [3:0]               i_digit_value,
    input  logic [1:0]               i_op_code,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_value,
    output logic [2:0]               o_status
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [DW-1:0]     r_depth, n_depth;
    logic [2:0]        r_err, n_err;
    logic [DATA_W-1:0] r_tos, n_tos;
    logic [1:0]        r_op, n_op;
    logic signed [2*DATA_W-1:0] r_prod, n_prod;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic [2:0]        r_out_status, n_out_status;

    logic              in_acc;
    logic              full;
    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     depth_m2;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;

    logic signed [DATA_W-1:0]   op_a;
    logic signed [DATA_W-1:0]   op_b;
    logic [DATA_W:0]            sum;
    logic signed [2*DATA_W-1:0] mul_full;
    logic                       sum_ovf;
    logic                       prod_ovf;
    logic                       div_zero;
    logic                       div_ovf;
    logic                       div_start;
    logic                       div_done;
    logic [DATA_W-1:0]          div_quo;

    // handshake: busy while an operator runs, end tokens wait for the output slot
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall && (i_kind == KIND_END));
    assign in_acc  = i_valid && !o_stall;

    // stack addressing, entries below the top of stack live in ram
    assign full     = (r_depth >= DW'(STACK_DEPTH));
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    assign ram_wr_en = in_acc && (i_kind == KIND_DIGIT) && (r_err == ST_OK) && !full
                       && (r_depth != '0);
    assign ram_rd_en = in_acc && (i_kind == KIND_OP) && (r_err == ST_OK)
                       && (r_depth >= DW'(2));

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (depth_m1[AW-1:0]),
        .i_wr_data (r_tos),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (depth_m2[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // operand arithmetic: first operand from ram, second is the top of stack
    assign op_a     = ram_rd_data;
    assign op_b     = r_tos;
    assign sum      = (r_op == OP_ADD) ? ({op_a[DATA_W-1], op_a} + {op_b[DATA_W-1], op_b})
                                       : ({op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b});
    assign sum_ovf  = ($signed(sum) >= $signed({1'b0, INT_MAX}))
                   || ($signed(sum) <= $signed({1'b1, INT_MIN}));
    assign mul_full = op_a * op_b;
    assign prod_ovf = (r_prod >= $signed({{DATA_W{1'b0}}, INT_MAX}))
                   || (r_prod <= $signed({{DATA_W{1'b1}}, INT_MIN}));
    assign div_zero = (op_b == '0);
    assign div_ovf  = (op_a == INT_MIN) && (op_b == '1);
    assign div_start = (r_state == S_READ) && (r_op == OP_DIV) && !div_zero && !div_ovf;

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (op_a),
        .i_divisor  (op_b),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // token sequencing and stack update
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_err        = r_err;
        n_tos        = r_tos;
        n_op         = r_op;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_kind == KIND_DIGIT) begin
                        if (r_err == ST_OK) begin
                            if (full) begin
                                n_err = ST_FULL;
                            end else begin
                                n_tos   = {{(DATA_W-4){1'b0}}, i_digit_value};
                                n_depth = r_depth + DW'(1);
                            end
                        end
                    end else if (i_kind == KIND_OP) begin
                        if (r_err == ST_OK) begin
                            if (r_depth < DW'(2)) begin
                                n_err = ST_MALFORMED;
                            end else begin
                                n_op    = i_op_code;
                                n_state = S_READ;
                            end
                        end
                    end else if (i_kind == KIND_END) begin
                        n_out_valid = 1'b1;
                        if (r_err != ST_OK) begin
                            n_out_value  = '0;
                            n_out_status = r_err;
                        end else if (r_depth == DW'(1)) begin
                            n_out_value  = r_tos;
                            n_out_status = ST_OK;
                        end else begin
                            n_out_value  = '0;
                            n_out_status = ST_MALFORMED;
                        end
                        n_depth = '0;
                        n_err   = ST_OK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        n_state = S_IDLE;
                        if (sum_ovf) begin
                            n_err = ST_OVERFLOW;
                        end else begin
                            n_tos   = sum[DATA_W-1:0];
                            n_depth = depth_m1;
                        end
                    end
                    OP_MUL: begin
                        n_prod  = mul_full;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        priority if (div_zero) begin
                            n_err   = ST_DIVZERO;
                            n_state = S_IDLE;
                        end else if (div_ovf) begin
                            n_err   = ST_OVERFLOW;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL: begin
                n_state = S_IDLE;
                if (prod_ovf) begin
                    n_err = ST_OVERFLOW;
                end else begin
                    n_tos   = r_prod[DATA_W-1:0];
                    n_depth = depth_m1;
                end
            end
            S_DIV: begin
                // first divider step runs here
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_tos   = div_quo;
                    n_depth = depth_m1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_op         <= n_op;
        r_prod       <= n_prod;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule

// File: hw/rtl/rpn_checker.sv
// rpn_checker: port-level checks for the evaluator, bound to the top level
// depends on rpn_pkg and rpn_stack_evaluator_top
`timescale 1ns / 1ps

module rpn_checker
    import rpn_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [1:0]        i_kind,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_value,
    input logic [2:0]        o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    // every taken end token yields a result next cycle
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind == KIND_END) |=> o_valid)
        else $error("end token gave no result");

    // a result only follows an end token
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && (i_kind == KIND_END)))
        else $error("result without end token");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_value == '0))
        else $error("nonzero value with error status");

endmodule

bind rpn_stack_evaluator_top rpn_checker u_rpn_checker (.*);
